@@ hw/rtl/rpct_pkg.sv @@
// Shared types and constants of the RGB pixel colour transform.
`timescale 1ns / 1ps
package rpct_pkg;

  localparam logic [3:0] MODE_C     = 4'd0;
  localparam logic [3:0] MODE_M     = 4'd1;
  localparam logic [3:0] MODE_Y     = 4'd2;
  localparam logic [3:0] MODE_H     = 4'd3;
  localparam logic [3:0] MODE_L     = 4'd4;
  localparam logic [3:0] MODE_S     = 4'd5;
  localparam logic [3:0] MODE_GRAY  = 4'd6;
  localparam logic [3:0] MODE_SEPIA = 4'd7;
  localparam logic [3:0] MODE_CMY   = 4'd8;
  localparam logic [3:0] MODE_HSL   = 4'd9;

  localparam int DVD_W   = 27;
  localparam int DVS_W   = 17;
  localparam int Q_W     = 8;
  localparam int N_LANES = 3;

  localparam logic [10:0] SEPIA_K_R = 11'd1351;
  localparam logic [10:0] SEPIA_K_G = 11'd1203;
  localparam logic [10:0] SEPIA_K_B = 11'd937;
  localparam logic [DVS_W-1:0] SEPIA_DEN = 17'd100000;
  localparam logic [DVD_W-1:0] SEPIA_LIMIT = 27'd25600000;
  localparam logic [DVS_W-1:0] GRAY_DEN = 17'd100;

  typedef struct packed {
    logic [DVD_W-1:0] rem;
    logic [DVS_W-1:0] dvs;
    logic [Q_W-1:0]   q;
  } lane_t;

  typedef struct packed {
    logic [3:0] mode;
    logic [7:0] light;
    logic [7:0] cy;
    logic [7:0] ma;
    logic [7:0] ye;
    logic [2:0] clip;
  } side_t;

  typedef struct packed {
    lane_t [N_LANES-1:0] lane;
    side_t               side;
  } stage_t;

endpackage

@@ hw/rtl/rgb_pixel_color_transform.sv @@
// Top level of the RGB pixel colour transform.
`timescale 1ns / 1ps
// One RGB pixel goes in on the slave stream and one three-channel result comes
// out on the master stream, in order. Input tdata carries red, green and blue
// from the lowest byte up; output tdata carries first, second and third channel.
// The mode register at byte address 0 of the APB port picks C, M, Y, H, L, S,
// gray, sepia, full CMY or full HSL; the user must write it only while the
// stream is idle, as the block does not enforce this. The pipeline takes one
// pixel per clock while it is not stalled. It has eleven register stages: two
// set-up stages (max, min and luma; then the products and divisor choice), eight
// stages of the restoring divider that yields one quotient bit each for hue,
// saturation, gray and sepia, and one stage for the output select and register.
// A result passes through these stages in order to the output register.
// All stages advance together whenever the output register is empty or is being
// taken, so while the receiver stalls with a result held, the whole pipeline
// holds and s_tready is low; nothing is lost or repeated. Empty slots in the
// pipeline keep moving while the output register is empty.
// A synchronous reset empties every stage and sets the mode to C.
module rgb_pixel_color_transform (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // first [7:0], second [15:8], third [23:16]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rpct_pkg::*;

  logic       adv;
  logic [3:0] mode;
  logic       pv, dv;
  stage_t     ps, ds;

  // The pipeline moves when the output slot is free or is being taken.
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign pready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_C;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      mode <= pwdata[3:0];
    end
  end

  assign prdata = (paddr[2] == 1'b0) ? {28'd0, mode} : 32'd0;

  rpct_prep u_prep (
    .clk(clk), .rst(rst), .en(adv), .in_valid(s_tvalid),
    .red(s_tdata[7:0]), .green(s_tdata[15:8]), .blue(s_tdata[23:16]),
    .mode(mode), .out_valid(pv), .out_stage(ps)
  );

  rpct_div_pipe u_div (
    .clk(clk), .rst(rst), .en(adv), .in_valid(pv), .in_stage(ps),
    .out_valid(dv), .out_stage(ds)
  );

  rpct_out u_out (
    .clk(clk), .rst(rst), .en(adv), .in_valid(dv), .in_stage(ds),
    .out_valid(m_tvalid), .out_data(m_tdata)
  );

endmodule

@@ hw/rtl/rpct_prep.sv @@
// Front stages: max, min and luma, then dividend and divisor set-up per lane.
`timescale 1ns / 1ps
module rpct_prep (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [7:0]           red,
  input  logic [7:0]           green,
  input  logic [7:0]           blue,
  input  logic [3:0]           mode,
  output logic                 out_valid,
  output rpct_pkg::stage_t     out_stage
);
  import rpct_pkg::*;

  logic [7:0]  mx_c, mn_c;
  logic [14:0] luma_c;

  logic        v1;
  logic [7:0]  r1, g1, b1, mx1, mn1;
  logic [14:0] luma1;
  logic [3:0]  mode1;

  logic [7:0]  c;
  logic [10:0] c6, num;
  logic [8:0]  sum;
  logic [DVD_W-1:0] hue_dvd, sat_dvd, gray_dvd;
  logic [DVS_W-1:0] hue_dvs, sat_dvs;
  logic [DVD_W-1:0] sep_r, sep_g, sep_b;
  stage_t      nxt;

  always_comb begin
    mx_c = (red > green) ? red : green;
    if (blue > mx_c) mx_c = blue;
    mn_c = (red < green) ? red : green;
    if (blue < mn_c) mn_c = blue;
    luma_c = 15'(red) * 15'd21 + 15'(green) * 15'd72 + 15'(blue) * 15'd7;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      r1 <= red; g1 <= green; b1 <= blue;
      mx1 <= mx_c; mn1 <= mn_c; luma1 <= luma_c; mode1 <= mode;
    end
  end

  always_comb begin
    c   = mx1 - mn1;
    c6  = 11'(c) * 11'd6;
    sum = 9'(mx1) + 9'(mn1);
    if (mx1 == r1) begin
      if (g1 >= b1) num = 11'(g1) - 11'(b1);
      else          num = c6 - (11'(b1) - 11'(g1));
    end else if (mx1 == g1) begin
      num = 11'(b1) + {2'b0, c, 1'b0} - 11'(r1);
    end else begin
      num = 11'(r1) + {1'b0, c, 2'b0} - 11'(g1);
    end
    // An achromatic pixel has hue zero: divide zero by one.
    if (c == 8'd0) begin
      hue_dvd = '0;
      hue_dvs = DVS_W'(1);
    end else begin
      hue_dvd = DVD_W'(num) * DVD_W'(255);
      hue_dvs = DVS_W'(c6);
    end
    // Black and white have saturation zero.
    if (sum == 9'd0 || sum >= 9'd510) begin
      sat_dvd = '0;
      sat_dvs = DVS_W'(1);
    end else begin
      sat_dvd = DVD_W'(c) * DVD_W'(255);
      sat_dvs = (sum < 9'd255) ? DVS_W'(sum) : DVS_W'(10'd510 - 10'(sum));
    end
    gray_dvd = DVD_W'(luma1);
    sep_r = DVD_W'(luma1) * DVD_W'(SEPIA_K_R);
    sep_g = DVD_W'(luma1) * DVD_W'(SEPIA_K_G);
    sep_b = DVD_W'(luma1) * DVD_W'(SEPIA_K_B);

    nxt = '0;
    for (int l = 0; l < N_LANES; l++) begin
      nxt.lane[l].dvs = DVS_W'(1);
    end
    nxt.side.mode  = mode1;
    nxt.side.light = sum[8:1];
    nxt.side.cy    = 8'd255 - r1;
    nxt.side.ma    = 8'd255 - g1;
    nxt.side.ye    = 8'd255 - b1;
    nxt.side.clip  = {sep_b >= SEPIA_LIMIT, sep_g >= SEPIA_LIMIT, sep_r >= SEPIA_LIMIT};
    case (mode1)
      MODE_H: begin
        nxt.lane[0].rem = hue_dvd; nxt.lane[0].dvs = hue_dvs;
      end
      MODE_S: begin
        nxt.lane[0].rem = sat_dvd; nxt.lane[0].dvs = sat_dvs;
      end
      MODE_GRAY: begin
        nxt.lane[0].rem = gray_dvd; nxt.lane[0].dvs = GRAY_DEN;
      end
      MODE_SEPIA: begin
        // A clipped channel divides zero so the quotient stays in range.
        nxt.lane[0].rem = nxt.side.clip[0] ? '0 : sep_r;
        nxt.lane[1].rem = nxt.side.clip[1] ? '0 : sep_g;
        nxt.lane[2].rem = nxt.side.clip[2] ? '0 : sep_b;
        nxt.lane[0].dvs = SEPIA_DEN;
        nxt.lane[1].dvs = SEPIA_DEN;
        nxt.lane[2].dvs = SEPIA_DEN;
      end
      MODE_HSL: begin
        nxt.lane[0].rem = hue_dvd; nxt.lane[0].dvs = hue_dvs;
        nxt.lane[2].rem = sat_dvd; nxt.lane[2].dvs = sat_dvs;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
    if (en) begin
      out_stage <= nxt;
    end
  end

endmodule

@@ hw/rtl/rpct_div_pipe.sv @@
// Eight-stage restoring divider, one quotient bit per stage on three lanes.
`timescale 1ns / 1ps
module rpct_div_pipe (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  rpct_pkg::stage_t  in_stage,
  output logic              out_valid,
  output rpct_pkg::stage_t  out_stage
);
  import rpct_pkg::*;

  stage_t       stg [Q_W];
  logic [Q_W-1:0] vld;

  // Every quotient fits in eight bits, so bit positions seven down to zero suffice.
  function automatic stage_t div_step(input stage_t x, input int unsigned bitpos);
    stage_t y;
    logic [DVD_W-1:0] t;
    y = x;
    for (int l = 0; l < N_LANES; l++) begin
      t = DVD_W'(x.lane[l].dvs) << bitpos;
      if (x.lane[l].rem >= t) begin
        y.lane[l].rem = x.lane[l].rem - t;
        y.lane[l].q[bitpos[2:0]] = 1'b1;
      end
    end
    return y;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Q_W-2:0], in_valid};
    end
    if (en) begin
      stg[0] <= div_step(in_stage, Q_W - 1);
      for (int j = 1; j < Q_W; j++) begin
        stg[j] <= div_step(stg[j-1], Q_W - 1 - j);
      end
    end
  end

  assign out_valid = vld[Q_W-1];
  assign out_stage = stg[Q_W-1];

endmodule

@@ hw/rtl/rpct_out.sv @@
// Output selection by mode and the output register.
`timescale 1ns / 1ps
module rpct_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  rpct_pkg::stage_t  in_stage,
  output logic              out_valid,
  output logic [23:0]       out_data
);
  import rpct_pkg::*;

  logic [7:0] o0, o1, o2;

  always_comb begin
    o0 = '0; o1 = '0; o2 = '0;
    case (in_stage.side.mode)
      MODE_C:    o0 = in_stage.side.cy;
      MODE_M:    o0 = in_stage.side.ma;
      MODE_Y:    o0 = in_stage.side.ye;
      MODE_H:    o0 = in_stage.lane[0].q;
      MODE_L:    o0 = in_stage.side.light;
      MODE_S:    o0 = in_stage.lane[0].q;
      MODE_GRAY: o0 = in_stage.lane[0].q;
      MODE_SEPIA: begin
        o0 = in_stage.side.clip[0] ? 8'd255 : in_stage.lane[0].q;
        o1 = in_stage.side.clip[1] ? 8'd255 : in_stage.lane[1].q;
        o2 = in_stage.side.clip[2] ? 8'd255 : in_stage.lane[2].q;
      end
      MODE_CMY: begin
        o0 = in_stage.side.cy; o1 = in_stage.side.ma; o2 = in_stage.side.ye;
      end
      MODE_HSL: begin
        o0 = in_stage.lane[0].q; o1 = in_stage.side.light; o2 = in_stage.lane[2].q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_data <= {o2, o1, o0};
    end
  end

endmodule

@@ hw/rtl/rpct_checker.sv @@
// Port-level checks on the colour transform, bound to the top level.
`timescale 1ns / 1ps
module rpct_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output slot");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result shown straight after reset");

endmodule

bind rgb_pixel_color_transform rpct_checker u_rpct_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
